/* hw/rtl/imu6lp_pkg.sv */
// Package for the six-axis IMU low-pass filter bank.
// Holds widths, filter coefficients, divider constants, word types and the
// shared floor-and-saturate function. Depends on nothing.
package imu6lp_pkg;

   localparam int SAMPLE_W  = 16;
   localparam int VALUE_W   = 32;
   localparam int FRAC_BITS = 16;
   localparam int COEF_BITS = 18;
   localparam int AVG_TAPS  = 5;

   // Filter accumulator width and the width left after dropping the
   // coefficient fraction bits.
   localparam int ACC_W   = 56;
   localparam int SHIFT_W = ACC_W - COEF_BITS;

   // Coefficients with COEF_BITS fraction bits.
   localparam logic signed [ACC_W-1:0] G3_INV  = ACC_W'(760);
   localparam logic signed [ACC_W-1:0] A0_COEF = ACC_W'(139480);
   localparam logic signed [ACC_W-1:0] A1_COEF = ACC_W'(-505769);
   localparam logic signed [ACC_W-1:0] A2_COEF = ACC_W'(622355);
   localparam logic signed [ACC_W-1:0] G2_INV  = ACC_W'(2050);
   localparam logic signed [ACC_W-1:0] B0_COEF = ACC_W'(-200804);
   localparam logic signed [ACC_W-1:0] B1_COEF = ACC_W'(454748);

   // Moving average divide: floor(n / AVG_TAPS) = (n * AVG_RECIP) >> DIV_SHIFT
   // for every magnitude n that the window sum can reach.
   localparam int SUM_W      = VALUE_W + $clog2(AVG_TAPS);
   localparam int DIV_SHIFT  = SUM_W + $clog2(AVG_TAPS);
   localparam int RECIP_W    = SUM_W + 1;
   localparam int RECIP_LO_W = RECIP_W / 2;
   localparam int RECIP_HI_W = RECIP_W - RECIP_LO_W;
   localparam logic [RECIP_W-1:0] AVG_RECIP =
      RECIP_W'(((64'd1 << DIV_SHIFT) + 64'(AVG_TAPS) - 64'd1) / 64'(AVG_TAPS));
   localparam logic [RECIP_LO_W-1:0] RECIP_LO = AVG_RECIP[RECIP_LO_W-1:0];
   localparam logic [RECIP_HI_W-1:0] RECIP_HI = AVG_RECIP[RECIP_W-1:RECIP_LO_W];

   // Register stages from an accepted word to a finished gyro result.
   localparam int GYRO_LAT = 5;

   // Result queue.
   localparam int RSP_DEPTH = 8;
   localparam int PTR_W     = $clog2(RSP_DEPTH);
   localparam int OCC_W     = $clog2(RSP_DEPTH + 1);

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [VALUE_W-1:0]  value_type;

   typedef struct packed {
      value_type gyro_x_smoothed;
      value_type gyro_y_smoothed;
      value_type gyro_z_smoothed;
      value_type accel_x_filtered;
      value_type accel_y_filtered;
      value_type accel_z_filtered;
   } rsp_word_type;

   // Drops the coefficient fraction bits (floor) and saturates to 32 bits.
   function automatic value_type sat_floor(input logic signed [ACC_W-1:0] acc);
      logic signed [SHIFT_W-1:0]   shifted;
      logic [SHIFT_W-VALUE_W:0]    upper;
      shifted = acc[ACC_W-1:COEF_BITS];
      upper   = shifted[SHIFT_W-1:VALUE_W-1];
      if ((&upper) || (~|upper)) begin
         return shifted[VALUE_W-1:0];
      end else if (shifted[SHIFT_W-1]) begin
         return {1'b1, {(VALUE_W-1){1'b0}}};
      end else begin
         return {1'b0, {(VALUE_W-1){1'b1}}};
      end
   endfunction

endpackage

/* hw/rtl/imu6lp_if.sv */
// Valid/ready channel interfaces for the sample and result words.
// Depends on imu6lp_pkg for field types.
interface imu6lp_req_if;
   logic                   valid;
   logic                   ready;
   imu6lp_pkg::sample_type gyro_x;
   imu6lp_pkg::sample_type gyro_y;
   imu6lp_pkg::sample_type gyro_z;
   imu6lp_pkg::sample_type accel_x;
   imu6lp_pkg::sample_type accel_y;
   imu6lp_pkg::sample_type accel_z;

   modport source (output valid, gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z,
                   input ready);
   modport sink (input valid, gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z,
                 output ready);
endinterface

interface imu6lp_rsp_if;
   logic                  valid;
   logic                  ready;
   imu6lp_pkg::value_type gyro_x_smoothed;
   imu6lp_pkg::value_type gyro_y_smoothed;
   imu6lp_pkg::value_type gyro_z_smoothed;
   imu6lp_pkg::value_type accel_x_filtered;
   imu6lp_pkg::value_type accel_y_filtered;
   imu6lp_pkg::value_type accel_z_filtered;

   modport source (output valid, gyro_x_smoothed, gyro_y_smoothed, gyro_z_smoothed,
                   accel_x_filtered, accel_y_filtered, accel_z_filtered,
                   input ready);
   modport sink (input valid, gyro_x_smoothed, gyro_y_smoothed, gyro_z_smoothed,
                 accel_x_filtered, accel_y_filtered, accel_z_filtered,
                 output ready);
endinterface

/* hw/rtl/imu_six_axis_lowpass_chain.sv */
// Top level of the six-axis IMU filter bank; uses imu6lp_pkg, imu6lp_if and the lane modules.
// An accepted word passes the lane stages, is written to the result queue, then is offered on rsp.
// Throughput: one sample word per cycle, sustained while rsp keeps taking result words.
// Five register stages per gyro lane; the filter feedback closes through the history registers.
// Synchronous active-high reset clears all filter histories, valid bits and the result queue;
// the block accepts words in the first cycle after reset.
module imu_six_axis_lowpass_chain (
   input logic          clock,
   input logic          reset,
   imu6lp_req_if.sink   req_port,
   imu6lp_rsp_if.source rsp_port
);

   // Handshake events on both sides.
   logic accept;
   logic deliver;

   // Words accepted and not yet delivered; this bounds the result queue.
   // Up to eight words may be in flight or waiting, so req stays ready while rsp stalls briefly.
   logic [imu6lp_pkg::OCC_W-1:0] occ_ff, occ_in;

   // One valid bit per gyro lane stage; the last one marks a finished word.
   logic [imu6lp_pkg::GYRO_LAT-1:0] vld_ff;

   imu6lp_pkg::sample_type gyro_sample  [3];
   imu6lp_pkg::sample_type accel_sample [3];
   imu6lp_pkg::value_type  gyro_out     [3];
   imu6lp_pkg::value_type  accel_out    [3];

   // The accelerometer result is ready after one stage; this delay line
   // lines it up with the gyro result of the same word.
   imu6lp_pkg::value_type accel_dly_ff [imu6lp_pkg::GYRO_LAT-1][3];

   imu6lp_pkg::rsp_word_type merge_word;

   // Result queue, written by the merge stage and read at the rsp port.
   imu6lp_pkg::rsp_word_type     fifo_ff [imu6lp_pkg::RSP_DEPTH];
   logic [imu6lp_pkg::PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [imu6lp_pkg::OCC_W-1:0] fifo_cnt_ff, fifo_cnt_in;
   logic                         merge_vld;

   assign accept  = req_port.valid && req_port.ready;
   assign deliver = rsp_port.valid && rsp_port.ready;

   // The block never takes more words than the queue can hold, so a
   // finished word always finds a free slot.
   assign req_port.ready = (occ_ff != imu6lp_pkg::OCC_W'(imu6lp_pkg::RSP_DEPTH));

   assign gyro_sample[0]  = req_port.gyro_x;
   assign gyro_sample[1]  = req_port.gyro_y;
   assign gyro_sample[2]  = req_port.gyro_z;
   assign accel_sample[0] = req_port.accel_x;
   assign accel_sample[1] = req_port.accel_y;
   assign accel_sample[2] = req_port.accel_z;

   // Three gyro lanes and three accelerometer lanes work side by side.
   for (genvar a = 0; a < 3; a++) begin : g_lane
      imu6lp_gyro_lane u_gyro (
         .clock    (clock),
         .reset    (reset),
         .accept   (accept),
         .sample   (gyro_sample[a]),
         .smoothed (gyro_out[a])
      );
      imu6lp_accel_lane u_accel (
         .clock    (clock),
         .reset    (reset),
         .accept   (accept),
         .sample   (accel_sample[a]),
         .filtered (accel_out[a])
      );
   end

   always_ff @(posedge clock) begin
      for (int a = 0; a < 3; a++) begin
         accel_dly_ff[0][a] <= accel_out[a];
         for (int s = 1; s < imu6lp_pkg::GYRO_LAT - 1; s++) begin
            accel_dly_ff[s][a] <= accel_dly_ff[s-1][a];
         end
      end
   end

   // Merge stage: the six lane results of one sample form one result word.
   assign merge_vld = vld_ff[imu6lp_pkg::GYRO_LAT-1];
   always_comb begin
      merge_word.gyro_x_smoothed  = gyro_out[0];
      merge_word.gyro_y_smoothed  = gyro_out[1];
      merge_word.gyro_z_smoothed  = gyro_out[2];
      merge_word.accel_x_filtered = accel_dly_ff[imu6lp_pkg::GYRO_LAT-2][0];
      merge_word.accel_y_filtered = accel_dly_ff[imu6lp_pkg::GYRO_LAT-2][1];
      merge_word.accel_z_filtered = accel_dly_ff[imu6lp_pkg::GYRO_LAT-2][2];
   end

   always_comb begin
      occ_in      = occ_ff + imu6lp_pkg::OCC_W'(accept) - imu6lp_pkg::OCC_W'(deliver);
      fifo_cnt_in = fifo_cnt_ff + imu6lp_pkg::OCC_W'(merge_vld)
                  - imu6lp_pkg::OCC_W'(deliver);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff      <= '0;
         vld_ff      <= '0;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         fifo_cnt_ff <= '0;
      end else begin
         occ_ff      <= occ_in;
         vld_ff      <= {vld_ff[imu6lp_pkg::GYRO_LAT-2:0], accept};
         fifo_cnt_ff <= fifo_cnt_in;
         if (merge_vld) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (deliver) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (merge_vld) begin
         fifo_ff[wr_ptr_ff] <= merge_word;
      end
   end

   assign rsp_port.valid            = (fifo_cnt_ff != '0);
   assign rsp_port.gyro_x_smoothed  = fifo_ff[rd_ptr_ff].gyro_x_smoothed;
   assign rsp_port.gyro_y_smoothed  = fifo_ff[rd_ptr_ff].gyro_y_smoothed;
   assign rsp_port.gyro_z_smoothed  = fifo_ff[rd_ptr_ff].gyro_z_smoothed;
   assign rsp_port.accel_x_filtered = fifo_ff[rd_ptr_ff].accel_x_filtered;
   assign rsp_port.accel_y_filtered = fifo_ff[rd_ptr_ff].accel_y_filtered;
   assign rsp_port.accel_z_filtered = fifo_ff[rd_ptr_ff].accel_z_filtered;

`ifndef SYNTHESIS
   // Every word in flight is either in a lane stage or in the queue.
   a_occ_matches : assert property (@(posedge clock) disable iff (reset)
      occ_ff == fifo_cnt_ff + imu6lp_pkg::OCC_W'($countones(vld_ff)))
      else $error("word count does not match lane stages plus queue");

   // A finished word never arrives at a full queue.
   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      !(merge_vld && fifo_cnt_ff == imu6lp_pkg::OCC_W'(imu6lp_pkg::RSP_DEPTH)))
      else $error("result queue overflow");

   // An accepted word reaches the merge stage after the lane latency.
   a_merge_timing : assert property (@(posedge clock) disable iff (reset)
      accept |=> ##(imu6lp_pkg::GYRO_LAT-1) merge_vld)
      else $error("accepted word did not reach the merge stage");
`endif

endmodule

/* hw/rtl/imu6lp_gyro_lane.sv */
// One gyro axis: third-order low-pass IIR followed by the moving average.
// Depends on imu6lp_pkg.
module imu6lp_gyro_lane (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  imu6lp_pkg::sample_type sample,
   output imu6lp_pkg::value_type  smoothed
);

   imu6lp_pkg::sample_type xh_ff  [3];
   imu6lp_pkg::value_type  yh_ff  [3];
   imu6lp_pkg::value_type  wnd_ff [imu6lp_pkg::AVG_TAPS];

   logic signed [imu6lp_pkg::ACC_W-1:0] xsum;
   logic signed [imu6lp_pkg::ACC_W-1:0] acc;
   imu6lp_pkg::value_type               lowpass_in;

   logic signed [imu6lp_pkg::SUM_W-1:0] sum_in, sum_ff;
   logic [imu6lp_pkg::SUM_W-1:0]        mag_ff;
   logic                                neg3_ff, neg4_ff;
   logic [imu6lp_pkg::SUM_W+imu6lp_pkg::RECIP_LO_W-1:0] pp_lo_ff;
   logic [imu6lp_pkg::SUM_W+imu6lp_pkg::RECIP_HI_W-1:0] pp_hi_ff;
   logic [imu6lp_pkg::SUM_W+imu6lp_pkg::RECIP_W-1:0]    prod;
   logic [imu6lp_pkg::VALUE_W-1:0]                      quot;
   imu6lp_pkg::value_type                               smoothed_in, smoothed_ff;

   // Filter recurrence; closes through the history registers.
   always_comb begin
      xsum = imu6lp_pkg::ACC_W'(sample) + imu6lp_pkg::ACC_W'(xh_ff[0])
           + 3 * (imu6lp_pkg::ACC_W'(xh_ff[1]) + imu6lp_pkg::ACC_W'(xh_ff[2]));
      acc  = ((xsum * imu6lp_pkg::G3_INV) <<< imu6lp_pkg::FRAC_BITS)
           + imu6lp_pkg::ACC_W'(yh_ff[2]) * imu6lp_pkg::A0_COEF
           + imu6lp_pkg::ACC_W'(yh_ff[1]) * imu6lp_pkg::A1_COEF
           + imu6lp_pkg::ACC_W'(yh_ff[0]) * imu6lp_pkg::A2_COEF;
      lowpass_in = imu6lp_pkg::sat_floor(acc);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            xh_ff[i] <= '0;
            yh_ff[i] <= '0;
         end
         for (int i = 0; i < imu6lp_pkg::AVG_TAPS; i++) begin
            wnd_ff[i] <= '0;
         end
      end else if (accept) begin
         xh_ff[2] <= xh_ff[1];
         xh_ff[1] <= xh_ff[0];
         xh_ff[0] <= sample;
         yh_ff[2] <= yh_ff[1];
         yh_ff[1] <= yh_ff[0];
         yh_ff[0] <= lowpass_in;
         for (int i = imu6lp_pkg::AVG_TAPS - 1; i > 0; i--) begin
            wnd_ff[i] <= wnd_ff[i-1];
         end
         wnd_ff[0] <= lowpass_in;
      end
   end

   always_comb begin
      sum_in = '0;
      for (int i = 0; i < imu6lp_pkg::AVG_TAPS; i++) begin
         sum_in = sum_in + imu6lp_pkg::SUM_W'(wnd_ff[i]);
      end
   end

   // The divide works on the magnitude so that the quotient truncates
   // toward zero; the reciprocal product is split in two halves.
   always_comb begin
      prod = {pp_hi_ff, imu6lp_pkg::RECIP_LO_W'(0)}
           + (imu6lp_pkg::SUM_W + imu6lp_pkg::RECIP_W)'(pp_lo_ff);
      quot = prod[imu6lp_pkg::DIV_SHIFT+imu6lp_pkg::VALUE_W-1:imu6lp_pkg::DIV_SHIFT];
      smoothed_in = neg4_ff ? -quot : quot;
   end

   always_ff @(posedge clock) begin
      sum_ff      <= sum_in;
      mag_ff      <= sum_ff[imu6lp_pkg::SUM_W-1] ? -sum_ff : sum_ff;
      neg3_ff     <= sum_ff[imu6lp_pkg::SUM_W-1];
      pp_lo_ff    <= mag_ff * imu6lp_pkg::RECIP_LO;
      pp_hi_ff    <= mag_ff * imu6lp_pkg::RECIP_HI;
      neg4_ff     <= neg3_ff;
      smoothed_ff <= smoothed_in;
   end

   assign smoothed = smoothed_ff;

endmodule

/* hw/rtl/imu6lp_accel_lane.sv */
// One accelerometer axis: second-order low-pass IIR.
// Depends on imu6lp_pkg.
module imu6lp_accel_lane (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  imu6lp_pkg::sample_type sample,
   output imu6lp_pkg::value_type  filtered
);

   imu6lp_pkg::sample_type xh_ff [2];
   imu6lp_pkg::value_type  yh_ff [2];

   logic signed [imu6lp_pkg::ACC_W-1:0] xsum;
   logic signed [imu6lp_pkg::ACC_W-1:0] acc;
   imu6lp_pkg::value_type               lowpass_in;

   always_comb begin
      xsum = imu6lp_pkg::ACC_W'(sample) + imu6lp_pkg::ACC_W'(xh_ff[1])
           + 2 * imu6lp_pkg::ACC_W'(xh_ff[0]);
      acc  = ((xsum * imu6lp_pkg::G2_INV) <<< imu6lp_pkg::FRAC_BITS)
           + imu6lp_pkg::ACC_W'(yh_ff[1]) * imu6lp_pkg::B0_COEF
           + imu6lp_pkg::ACC_W'(yh_ff[0]) * imu6lp_pkg::B1_COEF;
      lowpass_in = imu6lp_pkg::sat_floor(acc);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 2; i++) begin
            xh_ff[i] <= '0;
            yh_ff[i] <= '0;
         end
      end else if (accept) begin
         xh_ff[1] <= xh_ff[0];
         xh_ff[0] <= sample;
         yh_ff[1] <= yh_ff[0];
         yh_ff[0] <= lowpass_in;
      end
   end

   // The newest output history entry is the lane result.
   assign filtered = yh_ff[0];

endmodule
